[sv/aasc_pkg.sv]
`default_nettype none
package aasc_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned SizeWidth   = 2;

  // operation codes
  typedef enum logic [OpcodeWidth-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_ADDX = 3'd2,
    OP_SUBX = 3'd3,
    OP_NEG  = 3'd4,
    OP_NEGX = 3'd5,
    OP_CMP  = 3'd6
  } opcode_e;

  // operand size codes, the unused code behaves as long
  typedef enum logic [SizeWidth-1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1,
    SIZE_LONG = 2'd2
  } size_e;

  // spare codes: the opcode keeps the flags and yields a zero result, the size acts as long
  localparam logic [OpcodeWidth-1:0] OpReserved   = 3'd7;
  localparam logic [SizeWidth-1:0]   SizeReserved = 2'd3;

  // condition code register
  typedef struct packed {
    logic x;
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

endpackage
`default_nettype wire

[sv/aasc_if.sv]
`default_nettype none
// operation request channel
interface aasc_in_if;
  logic                               valid;
  logic                               ready;
  logic [aasc_pkg::OpcodeWidth-1:0]   opcode;
  logic [aasc_pkg::SizeWidth-1:0]     op_size;
  logic [aasc_pkg::DataWidth-1:0]     operand_a;
  logic [aasc_pkg::DataWidth-1:0]     operand_b;

  modport source (output valid, opcode, op_size, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, op_size, operand_a, operand_b, output ready);
endinterface

// result and condition code channel
interface aasc_out_if;
  logic                             valid;
  logic                             ready;
  logic [aasc_pkg::DataWidth-1:0]   result;
  logic                             flag_x;
  logic                             flag_n;
  logic                             flag_z;
  logic                             flag_v;
  logic                             flag_c;

  modport source (output valid, result, flag_x, flag_n, flag_z, flag_v, flag_c,
                  input ready);
  modport sink   (input valid, result, flag_x, flag_n, flag_z, flag_v, flag_c,
                  output ready);
endinterface
`default_nettype wire

[sv/alu_add_sub_condition_codes.sv]
// path: an input transfer passes the input register, then the result register, before
//   the earliest result transfer; a stalled output holds the result there
// throughput: one operation per cycle unless the output stalls; the flag register feeds
//   the next operation directly, so dependent extend-flag operations run back to back
// reset: asynchronous, clears both valid bits and all five flags
`default_nettype none
module alu_add_sub_condition_codes (
  input  logic         clk_i,
  input  logic         rst_ni,
  aasc_in_if.sink      in_i,
  aasc_out_if.source   out_o
);

  localparam int unsigned W = aasc_pkg::DataWidth;

  // input stage
  logic                           s1_valid_q;
  logic [aasc_pkg::OpcodeWidth-1:0] s1_op_q;
  logic [aasc_pkg::SizeWidth-1:0] s1_size_q;
  logic [W-1:0]                   s1_a_q;
  logic [W-1:0]                   s1_b_q;

  // result stage
  logic                           out_valid_q;
  logic [W-1:0]                   res_q;
  logic [W-1:0]                   res_d;
  aasc_pkg::flags_t               flags_q;
  aasc_pkg::flags_t               flags_d;

  logic in_xfer;
  logic out_free;
  logic s1_fire;

  // handshake
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_xfer  = in_i.valid && in_i.ready;

  // pick the sign bit of a sized value
  function automatic logic msb_of(input logic [W-1:0] val, input aasc_pkg::size_e sz);
    logic bit_o;
    unique case (sz)
      aasc_pkg::SIZE_BYTE: bit_o = val[7];
      aasc_pkg::SIZE_WORD: bit_o = val[15];
      default:             bit_o = val[W-1];
    endcase
    return bit_o;
  endfunction

  // datapath
  aasc_pkg::size_e size;
  logic [W-1:0]    mask;
  logic [W-1:0]    a_sz;
  logic [W-1:0]    b_sz;
  logic [W-1:0]    r;
  logic [W:0]      add_sum;
  logic [W:0]      sub_diff;
  logic            cin;
  logic            is_add;
  logic            sticky;
  logic            keep_x;
  logic            no_op;
  logic            zero_a;
  logic            c_add;
  logic            c;
  logic            v;
  logic            as;
  logic            bs;
  logic            rs;
  logic            r_zero;

  assign size = aasc_pkg::size_e'(s1_size_q);

  // operation decode
  always_comb begin
    is_add = 1'b0;
    sticky = 1'b0;
    keep_x = 1'b0;
    no_op  = 1'b0;
    zero_a = 1'b0;
    cin    = 1'b0;
    unique case (aasc_pkg::opcode_e'(s1_op_q))
      aasc_pkg::OP_ADD:  is_add = 1'b1;
      aasc_pkg::OP_SUB:  ;
      aasc_pkg::OP_ADDX: begin
        is_add = 1'b1;
        sticky = 1'b1;
        cin    = flags_q.x;
      end
      aasc_pkg::OP_SUBX: begin
        sticky = 1'b1;
        cin    = flags_q.x;
      end
      aasc_pkg::OP_NEG:  zero_a = 1'b1;
      aasc_pkg::OP_NEGX: begin
        zero_a = 1'b1;
        sticky = 1'b1;
        cin    = flags_q.x;
      end
      aasc_pkg::OP_CMP:  keep_x = 1'b1;
      default:           no_op  = 1'b1;
    endcase
  end

  // sized add and subtract, with the extend flag as a third operand for the extend operations
  always_comb begin
    unique case (size)
      aasc_pkg::SIZE_BYTE: mask = W'(32'h0000_00FF);
      aasc_pkg::SIZE_WORD: mask = W'(32'h0000_FFFF);
      default:             mask = '1;
    endcase
    a_sz     = zero_a ? '0 : (s1_a_q & mask);
    b_sz     = s1_b_q & mask;
    add_sum  = {1'b0, a_sz} + {1'b0, b_sz} + {{W{1'b0}}, cin};
    sub_diff = {1'b0, a_sz} - {1'b0, b_sz} - {{W{1'b0}}, cin};
    r        = (is_add ? add_sum[W-1:0] : sub_diff[W-1:0]) & mask;
    unique case (size)
      aasc_pkg::SIZE_BYTE: c_add = add_sum[8];
      aasc_pkg::SIZE_WORD: c_add = add_sum[16];
      default:             c_add = add_sum[W];
    endcase
    as     = msb_of(a_sz, size);
    bs     = msb_of(b_sz, size);
    rs     = msb_of(r, size);
    r_zero = (r == '0);
    c      = is_add ? c_add : sub_diff[W];
    v      = is_add ? (~(as ^ bs) & (as ^ rs)) : ((as ^ bs) & (as ^ rs));
  end

  // flag update
  always_comb begin
    if (no_op) begin
      res_d   = '0;
      flags_d = flags_q;
    end else begin
      res_d     = r;
      flags_d.c = c;
      flags_d.v = v;
      flags_d.n = rs;
      flags_d.z = sticky ? (flags_q.z & r_zero) : r_zero;
      flags_d.x = keep_x ? flags_q.x : c;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= in_xfer || (s1_valid_q && !s1_fire);
      out_valid_q <= s1_fire || (out_valid_q && !out_o.ready);
      if (s1_fire) begin
        flags_q <= flags_d;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= in_i.opcode;
      s1_size_q <= in_i.op_size;
      s1_a_q    <= in_i.operand_a;
      s1_b_q    <= in_i.operand_b;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  // flags_q loads together with the result register, so it is the result's flags
  assign out_o.valid  = out_valid_q;
  assign out_o.result = res_q;
  assign out_o.flag_x = flags_q.x;
  assign out_o.flag_n = flags_q.n;
  assign out_o.flag_z = flags_q.z;
  assign out_o.flag_v = flags_q.v;
  assign out_o.flag_c = flags_q.c;

endmodule
`default_nettype wire

[sv/aasc_checker.sv]
`default_nettype none
module aasc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic [aasc_pkg::OpcodeWidth-1:0]   in_opcode_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [aasc_pkg::DataWidth-1:0]     out_result_i,
  input logic                               out_flag_x_i,
  input logic                               out_flag_n_i,
  input logic                               out_flag_z_i,
  input logic                               out_flag_v_i,
  input logic                               out_flag_c_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i)
      && $stable({out_flag_x_i, out_flag_n_i, out_flag_z_i, out_flag_v_i, out_flag_c_i}))
    else $error("stalled result changed");

  // a ready sink never throttles the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled with output ready");

  // the input only stalls behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // an accepted input passes the input register and is a valid result when the sink is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after two cycles");

  // the unused opcode gives a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == aasc_pkg::OpReserved) ##1 out_ready_i
      |=> out_result_i == '0)
    else $error("unused opcode gave nonzero result");

endmodule

bind alu_add_sub_condition_codes aasc_checker u_aasc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result),
  .out_flag_x_i (out_o.flag_x),
  .out_flag_n_i (out_o.flag_n),
  .out_flag_z_i (out_o.flag_z),
  .out_flag_v_i (out_o.flag_v),
  .out_flag_c_i (out_o.flag_c)
);
`default_nettype wire
